[rtl/core/fdam_pkg.sv]
// ----------------------------------------------------------------------------
// fdam_pkg
// Shared types and constants of the feedback delay / moving average core.
// ----------------------------------------------------------------------------
`default_nettype none

package fdam_pkg;

	localparam int RING_DEPTH_DEF = 16384;

	localparam int SAMPLE_W = 24;
	localparam int OUT_W    = 21;
	localparam int GAIN_W   = 17;
	localparam int LEN_W    = 14;
	localparam int CFG_W    = 17;
	localparam int CFG_IDX_W = 2;

	// register reset values
	localparam logic [GAIN_W-1:0] GAIN_RST = 17'd32768;
	localparam logic [LEN_W-1:0]  LEN_RST  = 14'd5000;

	localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'd65536;
	localparam logic [LEN_W-1:0]  LEN_MAX    = 14'd9999;

	// length voltage: 9998 samples per 10 V, 10 V = 655360
	localparam logic [13:0] CV_SCALE = 14'd9998;
	// largest (cv*9998)>>16 that still maps to at most the 9998 clamp
	localparam logic [16:0] CV_Q_MAX = 17'd99989;

	// floor(x/10) = (x*DIV10_MULT) >> DIV10_SHIFT for x < 2**18
	localparam logic [16:0] DIV10_MULT  = 17'd104858;
	localparam int          DIV10_SHIFT = 20;

	localparam int SUM_W     = 34;
	localparam int DIV_STEPS = 33;

	localparam logic signed [25:0] OUT_POS_LIM = 26'sd655360;
	localparam logic signed [25:0] OUT_NEG_LIM = -26'sd655360;

	typedef enum logic [1:0] {
		REG_FEEDBACK_GAIN  = 2'd0,
		REG_LENGTH_SETTING = 2'd1,
		REG_LENGTH_FROM_CV = 2'd2,
		REG_AVERAGE_MODE   = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_LEN,
		S_AVG,
		S_RD,
		S_DLY,
		S_SUM,
		S_DIV,
		S_FIN,
		S_OUT
	} state_t;

endpackage

`default_nettype wire

[rtl/core/feedback_delay_with_average_mode_core.sv]
// ----------------------------------------------------------------------------
// Feedback delay with average mode - core
// Busy until the result is loaded, which waits out out_stall; the next item
// can be taken in the cycle it appears. Average mode reads n = length/10+1 ring
// samples (up to 1000), one per cycle, then runs the 33-step divider.
// Reset: registers to defaults; ring reads as zero until written (fill count).
// ----------------------------------------------------------------------------
`default_nettype none

module feedback_delay_with_average_mode_core #(
	parameter int RING_DEPTH = fdam_pkg::RING_DEPTH_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [fdam_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [fdam_pkg::CFG_W-1:0]             cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [fdam_pkg::SAMPLE_W-1:0]   in_sample,
	input  wire logic signed [fdam_pkg::SAMPLE_W-1:0]   feedback_sample,
	input  wire logic signed [fdam_pkg::SAMPLE_W-1:0]   length_cv,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [fdam_pkg::OUT_W-1:0]           out_sample
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int FW = $clog2(RING_DEPTH + 1);
	localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(RING_DEPTH);
	localparam logic [AW-1:0] PTR_LAST  = AW'(RING_DEPTH - 1);
	localparam logic [FW-1:0] FILL_FULL = FW'(RING_DEPTH);

	// configuration
	logic [fdam_pkg::GAIN_W-1:0] gain_q;
	logic [fdam_pkg::LEN_W-1:0]  len_set_q;
	logic                        from_cv_q;
	logic                        avg_mode_q;

	fdam_pkg::state_t state_q, state_nx;

	// item registers
	logic signed [23:0] x_q, f_q, cv_q;
	logic signed [23:0] fb_q;
	logic [20:0]        cvq_q;
	logic [13:0]        len_raw_q;
	logic [13:0]        len_q;
	logic [9:0]         n_q;
	logic [10:0]        i_q;
	logic signed [fdam_pkg::SUM_W-1:0] acc_q;
	logic [32:0]        dvd_q;
	logic [9:0]         rem_q;
	logic [5:0]         cnt_q;
	logic               neg_q;
	logic signed [25:0] y_q;

	logic [AW-1:0] wp_q;
	logic [FW-1:0] fill_q;

	logic                        out_valid_q;
	logic signed [20:0]          out_sample_q;

	// ring memory
	logic signed [23:0] ring_mem [RING_DEPTH];
	logic signed [23:0] rd_data_s1;
	logic               rd_pend_s1;
	logic               rd_ok_s1;

	// combinational helpers
	logic               rd_en;
	logic [13:0]        back_steps;
	logic [AW:0]        back_diff;
	logic [AW-1:0]      rd_addr;
	logic               rd_in_fill;
	logic               issue;
	logic               out_load;

	logic [17:0]        gain_eff;
	logic signed [41:0] fb_prod;
	logic [36:0]        cv_prod;
	logic [16:0]        cvq_clamp;
	logic [33:0]        cv_div_prod;
	logic [13:0]        len_cv;
	logic [13:0]        len_set_c;
	logic [30:0]        len_div_prod;
	logic signed [24:0] wr_sum;
	logic signed [23:0] wr_val;
	logic [11:0]        trial;
	logic signed [fdam_pkg::SUM_W-1:0] acc_abs;
	logic signed [24:0] mean;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q     <= fdam_pkg::GAIN_RST;
			len_set_q  <= fdam_pkg::LEN_RST;
			from_cv_q  <= 1'b0;
			avg_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				fdam_pkg::REG_FEEDBACK_GAIN:  gain_q     <= cfg_data[fdam_pkg::GAIN_W-1:0];
				fdam_pkg::REG_LENGTH_SETTING: len_set_q  <= cfg_data[fdam_pkg::LEN_W-1:0];
				fdam_pkg::REG_LENGTH_FROM_CV: from_cv_q  <= cfg_data[0];
				fdam_pkg::REG_AVERAGE_MODE:   avg_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------ arithmetic
	always_comb begin
		gain_eff = (gain_q > fdam_pkg::GAIN_UNITY) ? {1'b0, fdam_pkg::GAIN_UNITY}
		                                           : {1'b0, gain_q};
		fb_prod  = 42'(f_q) * $signed(42'(gain_eff));
		cv_prod  = 37'(cv_q[22:0]) * 37'(fdam_pkg::CV_SCALE);

		cvq_clamp   = (cvq_q > 21'(fdam_pkg::CV_Q_MAX)) ? fdam_pkg::CV_Q_MAX : cvq_q[16:0];
		cv_div_prod = 34'(cvq_clamp) * 34'(fdam_pkg::DIV10_MULT);
		len_cv      = 14'(cv_div_prod >> fdam_pkg::DIV10_SHIFT) + 14'd1;

		if (len_set_q == '0)
			len_set_c = 14'd1;
		else if (len_set_q > fdam_pkg::LEN_MAX)
			len_set_c = fdam_pkg::LEN_MAX;
		else
			len_set_c = len_set_q;

		len_div_prod = 31'(len_raw_q) * 31'(fdam_pkg::DIV10_MULT);

		wr_sum = 25'(x_q) + 25'(fb_q);
		if (wr_sum > 25'sd8388607)
			wr_val = 24'sh7FFFFF;
		else if (wr_sum < -25'sd8388608)
			wr_val = 24'sh800000;
		else
			wr_val = wr_sum[23:0];

		trial   = {1'b0, rem_q, dvd_q[32]} - {2'b00, n_q};
		acc_abs = acc_q[fdam_pkg::SUM_W-1] ? -acc_q : acc_q;
		mean    = neg_q ? -{1'b0, dvd_q[23:0]} : {1'b0, dvd_q[23:0]};
	end

	// ring read address: wp - steps, modulo the ring depth
	always_comb begin
		back_steps = (state_q == fdam_pkg::S_RD) ? len_q : 14'(i_q);
		back_diff  = {1'b0, wp_q} - (AW+1)'(back_steps);
		rd_addr    = back_diff[AW] ? AW'(back_diff + DEPTH_EXT) : back_diff[AW-1:0];
		rd_in_fill = FW'(back_steps) <= fill_q;
		issue      = i_q <= {1'b0, n_q};
	end

	// ----------------------------------------------------------------- FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= fdam_pkg::S_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		in_stall = 1'b1;
		rd_en    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			fdam_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid)
					state_nx = fdam_pkg::S_MUL;
			end
			fdam_pkg::S_MUL: state_nx = fdam_pkg::S_LEN;
			fdam_pkg::S_LEN: state_nx = fdam_pkg::S_AVG;
			fdam_pkg::S_AVG: state_nx = avg_mode_q ? fdam_pkg::S_SUM : fdam_pkg::S_RD;
			fdam_pkg::S_RD: begin
				rd_en    = 1'b1;
				state_nx = fdam_pkg::S_DLY;
			end
			fdam_pkg::S_DLY: state_nx = fdam_pkg::S_OUT;
			fdam_pkg::S_SUM: begin
				rd_en = issue;
				if (!issue && !rd_pend_s1)
					state_nx = fdam_pkg::S_DIV;
			end
			fdam_pkg::S_DIV: begin
				if (cnt_q == 6'd1)
					state_nx = fdam_pkg::S_FIN;
			end
			fdam_pkg::S_FIN: state_nx = fdam_pkg::S_OUT;
			fdam_pkg::S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_nx = fdam_pkg::S_IDLE;
				end
			end
			default: state_nx = fdam_pkg::S_IDLE;
		endcase
	end

	// ------------------------------------------------------------ memory
	always_ff @(posedge clk) begin
		if (state_q == fdam_pkg::S_LEN)
			ring_mem[wp_q] <= wr_val;
		if (rd_en)
			rd_data_s1 <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
			rd_ok_s1   <= 1'b0;
			wp_q       <= '0;
			fill_q     <= '0;
		end else begin
			rd_pend_s1 <= rd_en;
			rd_ok_s1   <= rd_en && rd_in_fill;
			if (state_q == fdam_pkg::S_LEN) begin
				wp_q <= (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
				if (fill_q != FILL_FULL)
					fill_q <= fill_q + 1'b1;
			end
		end
	end

	// ----------------------------------------------------------- datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q   <= '0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				fdam_pkg::S_AVG: i_q <= 11'd1;
				fdam_pkg::S_SUM: begin
					if (issue)
						i_q <= i_q + 11'd1;
					if (!issue && !rd_pend_s1)
						cnt_q <= 6'(fdam_pkg::DIV_STEPS);
				end
				fdam_pkg::S_DIV: cnt_q <= cnt_q - 6'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fdam_pkg::S_IDLE: begin
				x_q  <= in_sample;
				f_q  <= feedback_sample;
				cv_q <= length_cv;
			end
			fdam_pkg::S_MUL: begin
				fb_q  <= 24'(fb_prod >>> 16);
				cvq_q <= (cv_q > 24'sd0) ? cv_prod[36:16] : '0;
			end
			fdam_pkg::S_LEN: len_raw_q <= from_cv_q ? len_cv : len_set_c;
			fdam_pkg::S_AVG: begin
				if (avg_mode_q) begin
					len_q <= 14'(len_div_prod >> fdam_pkg::DIV10_SHIFT) + 14'd2;
					n_q   <= 10'(len_div_prod >> fdam_pkg::DIV10_SHIFT) + 10'd1;
				end else begin
					len_q <= len_raw_q;
					n_q   <= '0;
				end
				acc_q <= '0;
			end
			fdam_pkg::S_DLY: y_q <= rd_ok_s1 ? 26'(rd_data_s1) : '0;
			fdam_pkg::S_SUM: begin
				if (rd_ok_s1)
					acc_q <= acc_q + fdam_pkg::SUM_W'(rd_data_s1);
				if (!issue && !rd_pend_s1) begin
					dvd_q <= acc_abs[32:0];
					neg_q <= acc_q[fdam_pkg::SUM_W-1];
					rem_q <= '0;
				end
			end
			fdam_pkg::S_DIV: begin
				// restoring division, one quotient bit per cycle
				if (!trial[11]) begin
					rem_q <= trial[9:0];
					dvd_q <= {dvd_q[31:0], 1'b1};
				end else begin
					rem_q <= {rem_q[8:0], dvd_q[32]};
					dvd_q <= {dvd_q[31:0], 1'b0};
				end
			end
			fdam_pkg::S_FIN: y_q <= 26'(fb_q) - 26'(mean);
			default: ;
		endcase
	end

	// ------------------------------------------------------------- output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (y_q > fdam_pkg::OUT_POS_LIM)
				out_sample_q <= 21'(fdam_pkg::OUT_POS_LIM);
			else if (y_q < fdam_pkg::OUT_NEG_LIM)
				out_sample_q <= 21'(fdam_pkg::OUT_NEG_LIM);
			else
				out_sample_q <= y_q[20:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;

endmodule

`default_nettype wire

[rtl/core/fdam_checker.sv]
// ----------------------------------------------------------------------------
// fdam_checker
// Port-level checks of the feedback delay / moving average core.
// ----------------------------------------------------------------------------
`default_nettype none

module fdam_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 in_valid,
	input wire logic                                 in_stall,
	input wire logic                                 out_valid,
	input wire logic                                 out_stall,
	input wire logic signed [fdam_pkg::OUT_W-1:0]    out_sample
);

	// one item in work at a time: a transfer in closes the input
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while an item is in work");

	// a new result only follows a stretch in which the input side was busy
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without an item in work");

	a_out_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_sample <= 21'sd655360 && out_sample >= -21'sd655360))
		else $error("output beyond saturation limits");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_sample)))
		else $error("stalled output changed");

endmodule

bind feedback_delay_with_average_mode_core fdam_checker u_fdam_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_sample (out_sample)
);

`default_nettype wire

[test/feedback_delay_with_average_mode_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedback_delay_with_average_mode_core_tb
// Self-checking bench for the feedback delay / moving average core.
//
// What runs, in order:
//   - Directed samples: field extremes, gain above unity, out-of-range length
//     settings, length voltage clamps, and both delay and average mode.
//   - A delay-mode run of random samples with voltage-driven lengths.
//   - Random phases. Each phase writes every register and then sends random
//     samples. Average mode mostly uses short windows.
//
// A software copy of the ring predicts every output sample. Each output
// transfer is checked against the oldest prediction. The sender may pause
// between random bursts. The receiver stalls with a per-phase pattern.
// ----------------------------------------------------------------------------

module feedback_delay_with_average_mode_core_tb;

	import fdam_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int REPORT_CAP  = 200;
	localparam int DRAIN_WAIT  = 1100;
	localparam int DELAY_RUN_ITEMS = 60;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 38;

	localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 24'sh800000;
	localparam longint VOLT_10  = 655360;
	localparam longint CV_STEPS = 9998;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_style_t;

	// Mirror of the ring and the registers. Holds the predicted outputs in order.
	class delay_average_predictor;
		int                        ring_copy [RING_DEPTH_DEF];
		int                        wr_ptr;
		logic [GAIN_W-1:0]         gain_reg;
		logic [LEN_W-1:0]          len_reg;
		bit                        cv_len_en;
		bit                        avg_en;
		logic signed [OUT_W-1:0]   pending_out [$];
		int                        mismatches;

		function new();
			foreach (ring_copy[i]) ring_copy[i] = 0;
			wr_ptr     = 0;
			gain_reg   = GAIN_RST;
			len_reg    = LEN_RST;
			cv_len_en  = 1'b0;
			avg_en     = 1'b0;
			mismatches = 0;
		endfunction

		function void set_register(reg_idx_t idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_FEEDBACK_GAIN:  gain_reg  = data[GAIN_W-1:0];
				REG_LENGTH_SETTING: len_reg   = data[LEN_W-1:0];
				REG_LENGTH_FROM_CV: cv_len_en = data[0];
				REG_AVERAGE_MODE:   avg_en    = data[0];
				default: ;
			endcase
		endfunction

		function int ring_back(longint steps);
			return (wr_ptr + RING_DEPTH_DEF - int'(steps % RING_DEPTH_DEF)) % RING_DEPTH_DEF;
		endfunction

		// stores in + scaled feedback, then returns the delayed sample or feedback minus the mean
		function logic signed [OUT_W-1:0] predict_output(logic signed [SAMPLE_W-1:0] x,
				logic signed [SAMPLE_W-1:0] f, logic signed [SAMPLE_W-1:0] cv);
			longint                  g;
			longint                  fb;
			longint                  len;
			longint                  l;
			longint                  stored;
			longint                  y;
			longint                  sum;
			logic signed [OUT_W-1:0] r;
			g  = (gain_reg > GAIN_UNITY) ? longint'(GAIN_UNITY) : longint'(gain_reg);
			fb = (longint'(f) * g) >>> 16;
			if (cv_len_en) begin
				l = 0;
				if (cv > 0)
					l = (longint'(cv) * CV_STEPS) / VOLT_10;
				if (l > CV_STEPS)
					l = CV_STEPS;
				len = l + 1;
			end else begin
				len = longint'(len_reg);
				if (len < 1)
					len = 1;
				if (len > longint'(LEN_MAX))
					len = longint'(LEN_MAX);
			end
			if (avg_en)
				len = len / 10 + 2;
			stored = longint'(x) + fb;
			if (stored > longint'(SMP_MAX))
				stored = longint'(SMP_MAX);
			if (stored < longint'(SMP_MIN))
				stored = longint'(SMP_MIN);
			ring_copy[wr_ptr] = int'(stored);
			wr_ptr = (wr_ptr + 1) % RING_DEPTH_DEF;
			if (!avg_en) begin
				y = ring_copy[ring_back(len)];
			end else begin
				sum = 0;
				for (longint i = 1; i < len; i++)
					sum += ring_copy[ring_back(i)];
				y = fb - sum / (len - 1);
			end
			if (y > VOLT_10)
				y = VOLT_10;
			if (y < -VOLT_10)
				y = -VOLT_10;
			r = y[OUT_W-1:0];
			return r;
		endfunction

		function void note_sample(logic signed [SAMPLE_W-1:0] x,
				logic signed [SAMPLE_W-1:0] f, logic signed [SAMPLE_W-1:0] cv);
			pending_out.push_back(predict_output(x, f, cv));
		endfunction

		function void check_out(logic signed [OUT_W-1:0] act);
			logic signed [OUT_W-1:0] exp_val;
			if (pending_out.size() == 0) begin
				if (mismatches < REPORT_CAP)
					$display("%0t: unexpected out_sample transfer, actual %0d", $time, act);
				mismatches++;
			end else begin
				exp_val = pending_out.pop_front();
				if (exp_val !== act) begin
					if (mismatches < REPORT_CAP)
						$display("%0t: out_sample mismatch, expected %0d, actual %0d",
							$time, exp_val, act);
					mismatches++;
				end
			end
		endfunction

		function int pending();
			return pending_out.size();
		endfunction
	endclass

	logic                       clk             = 1'b0;
	logic                       arst_n          = 1'b0;
	logic                       cfg_we          = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index       = '0;
	logic [CFG_W-1:0]           cfg_data        = '0;
	logic                       in_valid        = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] in_sample       = '0;
	logic signed [SAMPLE_W-1:0] feedback_sample = '0;
	logic signed [SAMPLE_W-1:0] length_cv       = '0;
	logic                       out_valid;
	logic                       out_stall       = 1'b0;
	logic signed [OUT_W-1:0]    out_sample;

	delay_average_predictor out_predictor;

	stall_style_t stall_style = STALL_NONE;
	int           stall_tick  = 0;
	int           gap_max     = 0;
	int           burst_max   = 1;
	int           burst_left  = 0;
	int           cycle_count = 0;

	feedback_delay_with_average_mode_core #(
		.RING_DEPTH(RING_DEPTH_DEF)
	) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_sample       (in_sample),
		.feedback_sample (feedback_sample),
		.length_cv       (length_cv),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_sample      (out_sample)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		case (stall_style)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
			STALL_HEAVY:    out_stall <= ($urandom_range(0, 99) < 75);
			STALL_PERIODIC: out_stall <= ((stall_tick % 13) < 9);
			default:        out_stall <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			out_predictor.check_out(out_sample);
	end

	task automatic write_register(reg_idx_t idx, logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		out_predictor.set_register(idx, data);
		@(posedge clk);
	endtask

	// a new burst may start with a gap; valid stays up inside a burst
	task automatic send_sample(logic signed [SAMPLE_W-1:0] x,
			logic signed [SAMPLE_W-1:0] f, logic signed [SAMPLE_W-1:0] cv);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, burst_max);
			gap = $urandom_range(0, gap_max);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid        <= 1'b1;
		in_sample       <= x;
		feedback_sample <= f;
		length_cv       <= cv;
		do @(posedge clk); while (in_stall);
		out_predictor.note_sample(x, f, cv);
	endtask

	// block goes idle once every predicted output has been transferred
	task automatic settle();
		in_valid <= 1'b0;
		while (out_predictor.pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic pick_idling();
		case ($urandom_range(0, 3))
			0: begin
				gap_max = 0; burst_max = 64; stall_style = STALL_NONE;
			end
			1: begin
				gap_max = 3; burst_max = 8; stall_style = STALL_LIGHT;
			end
			2: begin
				gap_max = 12; burst_max = 3; stall_style = STALL_HEAVY;
			end
			default: begin
				gap_max = 5; burst_max = 16; stall_style = STALL_PERIODIC;
			end
		endcase
		burst_left = 0;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0:       return SMP_MAX;
			1:       return SMP_MIN;
			2, 3, 4: return SAMPLE_W'(int'($urandom_range(0, 1200000)) - 600000);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// narrow keeps average-mode windows short
	function automatic logic signed [SAMPLE_W-1:0] rand_cv(bit narrow);
		int pick;
		pick = $urandom_range(0, 4);
		if (narrow)
			return SAMPLE_W'(int'($urandom_range(0, 320000)) - 65536);
		case (pick)
			0:       return SAMPLE_W'($urandom);
			1:       return SAMPLE_W'($urandom_range(0, 700000));
			2:       return SAMPLE_W'(int'($urandom_range(0, 4000)) - 2000);
			3:       return ($urandom_range(0, 1) != 0) ? SMP_MAX : SMP_MIN;
			default: return SAMPLE_W'($urandom_range(0, 131072));
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_gain();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return CFG_W'(GAIN_UNITY);
			2:       return CFG_W'($urandom_range(65537, 131071));
			default: return CFG_W'($urandom_range(1, 65535));
		endcase
	endfunction

	initial begin
		bit               avg;
		bit               cv_en;
		bit               wide;
		logic [LEN_W-1:0] len;
		logic [CFG_W-1:0] data;

		out_predictor = new();
		pick_idling();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 5000-sample delay on an empty ring
		send_sample(SMP_MAX, SMP_MAX, SMP_MIN);
		send_sample(SMP_MIN, SMP_MIN, SMP_MAX);

		// gain above unity; a length setting of zero acts as one
		settle();
		write_register(REG_FEEDBACK_GAIN, 17'h1FFFF);
		write_register(REG_LENGTH_SETTING, 17'd0);
		send_sample(SMP_MAX, SMP_MAX, '0);
		send_sample(SMP_MIN, SMP_MIN, '0);
		send_sample('0, -24'sd1, '0);
		send_sample(24'sd1, '0, '0);

		// zero gain; a length setting above the maximum
		settle();
		write_register(REG_FEEDBACK_GAIN, 17'd0);
		write_register(REG_LENGTH_SETTING, 17'h03FFF);
		send_sample(24'sd12345, SMP_MAX, '0);

		// length from voltage: non-positive, 1 V, 10 V and full-scale clamps
		settle();
		write_register(REG_FEEDBACK_GAIN, CFG_W'(GAIN_UNITY));
		write_register(REG_LENGTH_FROM_CV, 17'd1);
		send_sample(rand_sample(), rand_sample(), '0);
		send_sample(rand_sample(), rand_sample(), -24'sd1);
		send_sample(rand_sample(), rand_sample(), SMP_MIN);
		send_sample(rand_sample(), rand_sample(), SMP_MAX);
		send_sample(rand_sample(), rand_sample(), 24'sd65536);
		send_sample(rand_sample(), rand_sample(), 24'sd655360);

		// average mode: shortest window, then the longest, by register and by voltage
		settle();
		write_register(REG_AVERAGE_MODE, 17'd1);
		write_register(REG_LENGTH_FROM_CV, 17'd0);
		write_register(REG_LENGTH_SETTING, 17'd1);
		send_sample(SMP_MAX, SMP_MAX, '0);
		send_sample(SMP_MIN, SMP_MIN, '0);
		send_sample(24'sd100000, -24'sd200000, '0);
		settle();
		write_register(REG_LENGTH_SETTING, CFG_W'(LEN_MAX));
		send_sample(rand_sample(), rand_sample(), '0);
		settle();
		write_register(REG_LENGTH_FROM_CV, 17'd1);
		send_sample(rand_sample(), rand_sample(), SMP_MAX);
		send_sample(rand_sample(), rand_sample(), '0);

		// delay-mode run with voltage-driven lengths
		settle();
		pick_idling();
		write_register(REG_AVERAGE_MODE, 17'd0);
		write_register(REG_FEEDBACK_GAIN, rand_gain());
		for (int n = 0; n < DELAY_RUN_ITEMS; n++)
			send_sample(rand_sample(), rand_sample(), rand_cv(1'b0));

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			pick_idling();
			avg   = 1'($urandom_range(0, 1));
			cv_en = 1'($urandom_range(0, 1));
			wide  = ($urandom_range(0, 5) == 0);
			len   = (avg && !wide) ? LEN_W'($urandom_range(0, 400))
				: LEN_W'($urandom_range(0, 16383));
			write_register(REG_FEEDBACK_GAIN, rand_gain());
			data = CFG_W'($urandom);
			data[LEN_W-1:0] = len;
			write_register(REG_LENGTH_SETTING, data);
			data = CFG_W'($urandom);
			data[0] = cv_en;
			write_register(REG_LENGTH_FROM_CV, data);
			data = CFG_W'($urandom);
			data[0] = avg;
			write_register(REG_AVERAGE_MODE, data);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_sample(rand_sample(), rand_sample(), rand_cv(avg && !wide));
		end

		settle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (out_predictor.mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
